// File: src/otsu_pkg.sv
// otsu_pkg: widths and bin constants for the otsu threshold selector
// used by otsu_threshold_select_core; no other dependencies

package otsu_pkg;

  // pixel count width, histogram bin width
  localparam int CountBits = 22;
  // intensity sum width: count times the largest gray level
  localparam int SumBits   = CountBits + 8;
  // T*W and S*N products
  localparam int ProdBits  = CountBits + SumBits;
  // squared difference
  localparam int NumBits   = 2 * ProdBits;
  // W*(N-W) denominator
  localparam int DenBits   = 2 * CountBits;
  // cross products used in the score compare
  localparam int AccBits   = NumBits + DenBits;

  // histogram geometry
  localparam int GrayBits  = 8;
  localparam int Bins      = 256;
  // last bin visited by the threshold walk
  localparam int LastBin   = Bins - 2;

endpackage

// File: src/otsu_threshold_select_core.sv
// otsu_threshold_select_core: histogram accumulation and otsu threshold search
// one shift-add multiplier shared by all products of the score; depends on otsu_pkg
//
// pixel handling: each pixel is a histogram read, then the write back; after the last
// pixel the walk reads, accumulates and checks each bin, and a bin with W=0 or W=N goes no
// further; any other bin multiplies by W, N, |TW-SN|, N-W, best W*(N-W) and W*(N-W) in turn,
// one multiplier bit per cycle; the result follows, then a histogram clear pass
// reset: starts with the same clear pass, no pixel request is taken meanwhile

module otsu_threshold_select_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [otsu_pkg::GrayBits-1:0] s_axis_tdata,   // [7:0] gray
  input  logic                          s_axis_tlast,   // last_pixel
  // threshold results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [otsu_pkg::GrayBits-1:0] m_axis_tdata,   // [7:0] threshold
  output logic                          m_axis_tuser    // [0] count_overflow
);

  // sequencer states
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StIncr  = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StAccum = 3'd4;
  localparam logic [2:0] StCheck = 3'd5;
  localparam logic [2:0] StMul   = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  // which product the multiplier is working on
  localparam logic [2:0] StepTw  = 3'd0;
  localparam logic [2:0] StepSn  = 3'd1;
  localparam logic [2:0] StepSq  = 3'd2;
  localparam logic [2:0] StepDen = 3'd3;
  localparam logic [2:0] StepLhs = 3'd4;
  localparam logic [2:0] StepRhs = 3'd5;

  localparam logic [otsu_pkg::GrayBits-1:0] LastBinIdx  =
    otsu_pkg::GrayBits'(otsu_pkg::LastBin);
  localparam logic [otsu_pkg::GrayBits-1:0] LastClearIdx =
    otsu_pkg::GrayBits'(otsu_pkg::Bins - 1);
  localparam logic [otsu_pkg::CountBits-1:0] CountMax = {otsu_pkg::CountBits{1'b1}};

  // control registers
  logic [2:0]                          state_q, state_d;
  logic [otsu_pkg::GrayBits-1:0]       idx_q, idx_d;
  logic [otsu_pkg::CountBits-1:0]      count_q, count_d;
  logic [otsu_pkg::SumBits-1:0]        sum_q, sum_d;
  logic                                ovf_q, ovf_d;
  logic                                out_valid_q, out_valid_d;

  // payload registers
  logic [otsu_pkg::GrayBits-1:0]       gray_q, gray_d;
  logic                                last_q, last_d;
  logic                                keep_q, keep_d;
  logic [otsu_pkg::CountBits-1:0]      w_q, w_d;
  logic [otsu_pkg::SumBits-1:0]        s_q, s_d;
  logic [2:0]                          step_q, step_d;
  logic [otsu_pkg::AccBits-1:0]        acc_q, acc_d;
  logic [otsu_pkg::AccBits-1:0]        mcand_q, mcand_d;
  logic [otsu_pkg::ProdBits-1:0]       mplier_q, mplier_d;
  logic [otsu_pkg::ProdBits-1:0]       tw_q, tw_d;
  logic [otsu_pkg::NumBits-1:0]        num_q, num_d;
  logic [otsu_pkg::DenBits-1:0]        den_q, den_d;
  logic [otsu_pkg::AccBits-1:0]        lhs_q, lhs_d;
  logic [otsu_pkg::NumBits-1:0]        best_num_q, best_num_d;
  logic [otsu_pkg::DenBits-1:0]        best_den_q, best_den_d;
  logic [otsu_pkg::GrayBits-1:0]       best_q, best_d;
  logic [otsu_pkg::GrayBits-1:0]       out_thr_q, out_thr_d;
  logic                                out_ovf_q, out_ovf_d;

  // histogram memory
  logic [otsu_pkg::CountBits-1:0]      hist_mem [otsu_pkg::Bins];
  logic [otsu_pkg::CountBits-1:0]      rd_q;
  logic                                mem_we;
  logic [otsu_pkg::GrayBits-1:0]       mem_waddr;
  logic [otsu_pkg::GrayBits-1:0]       mem_raddr;
  logic [otsu_pkg::CountBits-1:0]      mem_wdata;

  // walk helpers
  logic [otsu_pkg::SumBits-1:0]        bin_prod;
  logic [otsu_pkg::ProdBits-1:0]       sn_val;
  logic [otsu_pkg::ProdBits-1:0]       diff;
  logic                                bin_done;

  assign bin_prod = otsu_pkg::SumBits'(idx_q) * otsu_pkg::SumBits'(rd_q);
  assign sn_val   = acc_q[otsu_pkg::ProdBits-1:0];
  assign diff     = (tw_q >= sn_val) ? (tw_q - sn_val) : (sn_val - tw_q);

  // ports
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_thr_q;
  assign m_axis_tuser  = out_ovf_q;

  // sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    gray_d      = gray_q;
    last_d      = last_q;
    keep_d      = keep_q;
    w_d         = w_q;
    s_d         = s_q;
    step_d      = step_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    tw_d        = tw_q;
    num_d       = num_q;
    den_d       = den_q;
    lhs_d       = lhs_q;
    best_num_d  = best_num_q;
    best_den_d  = best_den_q;
    best_d      = best_q;
    out_thr_d   = out_thr_q;
    out_ovf_d   = out_ovf_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mem_raddr   = idx_q;
    bin_done    = 1'b0;

    // result taken downstream
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StClear: begin
        mem_we = 1'b1;
        idx_d  = idx_q + otsu_pkg::GrayBits'(1);
        if (idx_q == LastClearIdx) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        mem_raddr = s_axis_tdata;
        if (s_axis_tvalid) begin
          gray_d  = s_axis_tdata;
          last_d  = s_axis_tlast;
          state_d = StIncr;
          if (count_q == CountMax) begin
            ovf_d  = 1'b1;
            keep_d = 1'b0;
          end else begin
            keep_d  = 1'b1;
            count_d = count_q + otsu_pkg::CountBits'(1);
            sum_d   = sum_q + otsu_pkg::SumBits'(s_axis_tdata);
          end
        end
      end
      StIncr: begin
        // write back the incremented bin
        mem_we    = keep_q;
        mem_waddr = gray_q;
        mem_wdata = rd_q + otsu_pkg::CountBits'(1);
        if (last_q) begin
          idx_d      = '0;
          w_d        = '0;
          s_d        = '0;
          best_num_d = '0;
          best_den_d = otsu_pkg::DenBits'(1);
          best_d     = '0;
          state_d    = StRead;
        end else begin
          state_d = StIdle;
        end
      end
      StRead: begin
        state_d = StAccum;
      end
      StAccum: begin
        // running count and sum up to this bin
        w_d     = w_q + rd_q;
        s_d     = s_q + bin_prod;
        state_d = StCheck;
      end
      StCheck: begin
        if (w_q == '0 || w_q >= count_q) begin
          bin_done = 1'b1;
        end else begin
          acc_d    = '0;
          mcand_d  = otsu_pkg::AccBits'(sum_q);
          mplier_d = otsu_pkg::ProdBits'(w_q);
          step_d   = StepTw;
          state_d  = StMul;
        end
      end
      StMul: begin
        if (mplier_q != '0) begin
          // one shift-add step
          if (mplier_q[0]) begin
            acc_d = acc_q + mcand_q;
          end
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end else begin
          // product ready: store it and load the next one
          acc_d = '0;
          unique case (step_q)
            StepTw: begin
              tw_d     = acc_q[otsu_pkg::ProdBits-1:0];
              mcand_d  = otsu_pkg::AccBits'(s_q);
              mplier_d = otsu_pkg::ProdBits'(count_q);
              step_d   = StepSn;
            end
            StepSn: begin
              mcand_d  = otsu_pkg::AccBits'(diff);
              mplier_d = diff;
              step_d   = StepSq;
            end
            StepSq: begin
              num_d    = acc_q[otsu_pkg::NumBits-1:0];
              mcand_d  = otsu_pkg::AccBits'(w_q);
              mplier_d = otsu_pkg::ProdBits'(count_q - w_q);
              step_d   = StepDen;
            end
            StepDen: begin
              den_d    = acc_q[otsu_pkg::DenBits-1:0];
              mcand_d  = otsu_pkg::AccBits'(num_q);
              mplier_d = otsu_pkg::ProdBits'(best_den_q);
              step_d   = StepLhs;
            end
            StepLhs: begin
              lhs_d    = acc_q;
              mcand_d  = otsu_pkg::AccBits'(best_num_q);
              mplier_d = otsu_pkg::ProdBits'(den_q);
              step_d   = StepRhs;
            end
            StepRhs: begin
              // strictly greater score replaces the best
              if (lhs_q > acc_q) begin
                best_num_d = num_q;
                best_den_d = den_q;
                best_d     = idx_q;
              end
              bin_done = 1'b1;
            end
            default: begin
              bin_done = 1'b1;
            end
          endcase
        end
      end
      StOut: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_thr_d   = best_q;
          out_ovf_d   = ovf_q;
          count_d     = '0;
          sum_d       = '0;
          ovf_d       = 1'b0;
          idx_d       = '0;
          state_d     = StClear;
        end
      end
      default: begin
        idx_d   = '0;
        state_d = StClear;
      end
    endcase

    // advance to the next bin or finish the walk
    if (bin_done) begin
      if (idx_q == LastBinIdx) begin
        state_d = StOut;
      end else begin
        idx_d   = idx_q + otsu_pkg::GrayBits'(1);
        state_d = StRead;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      idx_q       <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    gray_q     <= gray_d;
    last_q     <= last_d;
    keep_q     <= keep_d;
    w_q        <= w_d;
    s_q        <= s_d;
    step_q     <= step_d;
    acc_q      <= acc_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    tw_q       <= tw_d;
    num_q      <= num_d;
    den_q      <= den_d;
    lhs_q      <= lhs_d;
    best_num_q <= best_num_d;
    best_den_q <= best_den_d;
    best_q     <= best_d;
    out_thr_q  <= out_thr_d;
    out_ovf_q  <= out_ovf_d;
  end

  // histogram memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= hist_mem[mem_raddr];
  end

endmodule

// File: tb/sv/otsu_threshold_select_core_tb.sv
// otsu_threshold_select_core_tb: self-checking bench for the otsu threshold selector
// streams gray images, predicts each threshold with exact wide arithmetic
// depends on otsu_pkg and otsu_threshold_select_core

module otsu_threshold_select_core_tb;

  localparam int CycleLimit   = 10_000_000;
  localparam int PixelsPerPhase = 225;
  localparam int HoldOffCycles  = 5000;
  localparam int SettleCycles   = 300;

  typedef enum int {ImgFull, ImgNarrow, ImgTwoLevel, ImgFlat} image_kind_e;

  // expected thresholds, built from the same pixel stream the block accepts
  class threshold_scoreboard;
    typedef struct {
      bit [otsu_pkg::GrayBits-1:0] threshold;
      bit                          count_overflow;
    } otsu_result_t;

    bit [otsu_pkg::CountBits-1:0] bin_count [otsu_pkg::Bins];
    bit [otsu_pkg::CountBits-1:0] pixel_total;
    bit [otsu_pkg::SumBits-1:0]   gray_sum;
    bit                           dropped_pixel;
    otsu_result_t                 expected_results [$];
    int                           mismatches;

    function new();
      clear_image();
      mismatches = 0;
    endfunction

    function void clear_image();
      foreach (bin_count[i]) bin_count[i] = '0;
      pixel_total   = '0;
      gray_sum      = '0;
      dropped_pixel = 1'b0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // walk bins 0..254, keep the first strictly greatest between-class score
    function bit [otsu_pkg::GrayBits-1:0] best_split();
      bit [otsu_pkg::AccBits-1:0]  w, s, n, t, tw, sn, diff, num, den, best_num, best_den;
      bit [otsu_pkg::GrayBits-1:0] best;
      n = pixel_total;
      t = gray_sum;
      w = '0;
      s = '0;
      best_num = '0;
      best_den = 1;
      best = '0;
      for (int b = 0; b <= otsu_pkg::LastBin; b++) begin
        w += bin_count[b];
        s += b * bin_count[b];
        if (w == 0 || w >= n) continue;
        tw   = t * w;
        sn   = s * n;
        diff = (tw >= sn) ? tw - sn : sn - tw;
        num  = diff * diff;
        den  = w * (n - w);
        // cross-multiplied compare, ties keep the earlier bin
        if (num * best_den > best_num * den) begin
          best_num = num;
          best_den = den;
          best     = b[otsu_pkg::GrayBits-1:0];
        end
      end
      return best;
    endfunction

    // one accepted pixel request
    function void note_pixel(bit [otsu_pkg::GrayBits-1:0] gray, bit last_pixel);
      otsu_result_t r;
      if (pixel_total == '1) begin
        dropped_pixel = 1'b1;
      end else begin
        bin_count[gray]++;
        pixel_total++;
        gray_sum += gray;
      end
      if (last_pixel) begin
        r.threshold      = best_split();
        r.count_overflow = dropped_pixel;
        expected_results.push_back(r);
        clear_image();
      end
    endfunction

    function void report_mismatch(string what, int want, int got);
      if (mismatches < 10)
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      mismatches++;
    endfunction

    // one accepted threshold result
    function void check_result(bit [otsu_pkg::GrayBits-1:0] threshold, bit count_overflow);
      otsu_result_t r;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, threshold", -1, threshold);
        return;
      end
      r = expected_results.pop_front();
      if (threshold != r.threshold) report_mismatch("threshold", r.threshold, threshold);
      if (count_overflow != r.count_overflow)
        report_mismatch("count_overflow", r.count_overflow, count_overflow);
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [otsu_pkg::GrayBits-1:0] s_axis_tdata;
  logic                          s_axis_tlast;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [otsu_pkg::GrayBits-1:0] m_axis_tdata;
  logic                          m_axis_tuser;

  threshold_scoreboard board = new();
  int                  src_idle_pct;
  int                  sink_stall_pct;
  int                  hold_left;
  int                  pixels_sent;
  int                  cycle_count;

  otsu_threshold_select_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result receiver: random stalls plus a counted hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tuser);
  end

  // one pixel request, with random idle cycles ahead of it
  task automatic send_pixel(input logic [otsu_pkg::GrayBits-1:0] gray,
                            input logic last_pixel);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom_range(255);
      s_axis_tlast  <= $urandom_range(1);
      @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= gray;
    s_axis_tlast  <= last_pixel;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_pixel(gray, last_pixel);
    pixels_sent++;
  endtask

  // one image of the given shape, last pixel marked
  task automatic send_image(input image_kind_e kind, input int len);
    int lo;
    int hi;
    int spread;
    int v;
    lo     = $urandom_range(255);
    hi     = $urandom_range(255);
    spread = $urandom_range(15);
    for (int i = 0; i < len; i++) begin
      case (kind)
        ImgFull:     v = $urandom_range(255);
        ImgNarrow: begin
          v = lo + $urandom_range(spread);
          if (v > 255) v = 255;
        end
        ImgTwoLevel: v = $urandom_range(1) ? lo : hi;
        default:     v = lo;
      endcase
      send_pixel(v[otsu_pkg::GrayBits-1:0], i == len - 1);
    end
  endtask

  // sender pause until every pending threshold has come back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    image_kind_e kind;
    int          pick;
    int          len;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 0;
    pixels_sent    = 0;
    cycle_count    = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // one-pixel images at both gray extremes
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    // widest split
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    // equal scores over bins 10..19, the first one wins
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd20, 1'b1);
    // single-level image scores nothing
    send_pixel(8'd77, 1'b0);
    send_pixel(8'd77, 1'b0);
    send_pixel(8'd77, 1'b1);
    // mixed extremes
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd127, 1'b1);
    // two clusters
    send_pixel(8'd30, 1'b0);
    send_pixel(8'd31, 1'b0);
    send_pixel(8'd32, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd201, 1'b0);
    send_pixel(8'd202, 1'b1);
    drain_results();

    // random images under four idling mixes
    // count saturation needs about four million pixels and stays out of this run
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 65; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 65; end
        default: begin src_idle_pct = 35; sink_stall_pct = 35; end
      endcase
      // long receiver hold-off while images keep coming, so the input backs up
      if (phase == 2) begin
        hold_left = HoldOffCycles;
        repeat (3) send_image(ImgNarrow, $urandom_range(2, 6));
      end
      while (pixels_sent < (phase + 1) * PixelsPerPhase + 21) begin
        pick = $urandom_range(99);
        if (pick < 30)      kind = ImgFull;
        else if (pick < 65) kind = ImgNarrow;
        else if (pick < 85) kind = ImgTwoLevel;
        else                kind = ImgFlat;
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 30);
        send_image(kind, len);
      end
      drain_results();
    end

    // let the final clear pass finish
    repeat (SettleCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: otsu_threshold_select_core.f
src/otsu_pkg.sv
src/otsu_threshold_select_core.sv
tb/sv/otsu_threshold_select_core_tb.sv
